// ===== design/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg : shared constants and helpers for the digraph cipher core
// Letter codes, command codes, register indexes and square geometry helpers.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int NUM_CELLS   = 25;
    localparam int SIDE        = 5;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] LETTER_Z = 5'd25;

    // command codes carried on s_tuser
    localparam logic [1:0] CMD_KEY_LETTER = 2'd0;
    localparam logic [1:0] CMD_KEY_DONE   = 2'd1;
    localparam logic [1:0] CMD_MSG_LETTER = 2'd2;
    localparam logic [1:0] CMD_MSG_END    = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DECRYPT_MODE  = 2'd0;
    localparam logic [1:0] REG_FILLER_LETTER = 2'd1;
    localparam logic [1:0] REG_PAD_LETTER    = 2'd2;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    // clamp to z, then fold j into i
    function automatic letter_t fold_letter(input letter_t v);
        letter_t c;
        c = (v > LETTER_Z) ? LETTER_Z : v;
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    // row of a cell index 0..24 (division by five as a compare chain)
    function automatic coord_t cell_row(input cell_t idx);
        coord_t r;
        if (idx >= 5'd20)
        begin
            r = 3'd4;
        end
        else if (idx >= 5'd15)
        begin
            r = 3'd3;
        end
        else if (idx >= 5'd10)
        begin
            r = 3'd2;
        end
        else if (idx >= 5'd5)
        begin
            r = 3'd1;
        end
        else
        begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic cell_t cell_index(input coord_t row, input coord_t col);
        return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic coord_t cell_col(input cell_t idx, input coord_t row);
        cell_t base;
        base = cell_index(row, 3'd0);
        return 3'(idx - base);
    endfunction

    // one step around a row or column: forward for encrypt, back for decrypt
    function automatic coord_t wrap_step(input coord_t v, input logic back);
        coord_t r;
        if (back)
        begin
            r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end
        else
        begin
            r = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== design/playfair_digraph_cipher_core.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core : 5x5 key square digraph cipher
// Builds the key square from key letters, then enciphers or deciphers
// message letters two at a time through a small lookup sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                   Transfer when
//  s_*       in   tdata[4:0] letter, tuser[1:0] cmd          s_tvalid & s_tready
//  m_*       out  tdata[4:0] out_letter, tlast pair_last,    m_tvalid & m_tready
//                 tuser[0] message_end
//  APB       in   0x0 decrypt_mode, 0x4 filler, 0x8 pad      psel&penable&pwrite
//
//  Key letters and message letters that complete no pair are taken in IDLE.
//  Key done walks every letter code in turn through the shared placement path
//  in the FILL state, and that path writes both square memories.
//  A letter or end of message completing a digraph runs LKA through OUT2 plus
//  any output stall: the single read port of each memory is used twice.
//  Reset clears the used-letter flags (j marked used), the fill count and the
//  held letter; the square memories need no clearing.
//  s_tready is low while a key fill or a digraph is in flight; m_tvalid holds
//  until the result transfer, and the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] letter, [7:5] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [4:0] out_letter, [7:5] zero
    output logic        m_tlast,   // pair_last
    output logic [0:0]  m_tuser,   // [0] message_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_LKA  = 4'd2;
    localparam logic [3:0] ST_LKB  = 4'd3;
    localparam logic [3:0] ST_CALC = 4'd4;
    localparam logic [3:0] ST_SQ1  = 4'd5;
    localparam logic [3:0] ST_SQ2  = 4'd6;
    localparam logic [3:0] ST_OUT1 = 4'd7;
    localparam logic [3:0] ST_OUT2 = 4'd8;

    // ---------------- configuration registers ----------------
    logic               decrypt_mode_reg;
    pfc_pkg::letter_t   filler_letter_reg;
    pfc_pkg::letter_t   pad_letter_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg  <= 1'b0;
            filler_letter_reg <= pfc_pkg::LETTER_X;
            pad_letter_reg    <= pfc_pkg::LETTER_Z;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                pfc_pkg::REG_DECRYPT_MODE:  decrypt_mode_reg  <= pwdata[0];
                pfc_pkg::REG_FILLER_LETTER: filler_letter_reg <= pwdata[4:0];
                pfc_pkg::REG_PAD_LETTER:    pad_letter_reg    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pfc_pkg::REG_DECRYPT_MODE:  prdata = {31'd0, decrypt_mode_reg};
            pfc_pkg::REG_FILLER_LETTER: prdata = {27'd0, filler_letter_reg};
            pfc_pkg::REG_PAD_LETTER:    prdata = {27'd0, pad_letter_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- control state ----------------
    logic [3:0]         state_reg, state_next;
    logic [25:0]        used_reg, used_next;
    logic [4:0]         fill_count_reg, fill_count_next;
    logic [4:0]         key_idx_reg, key_idx_next;
    logic               square_ready_reg, square_ready_next;
    pfc_pkg::letter_t   held_letter_reg, held_letter_next;
    logic               held_valid_reg, held_valid_next;

    // digraph datapath registers
    pfc_pkg::letter_t   pair_a_reg, pair_a_next;
    pfc_pkg::letter_t   pair_b_reg, pair_b_next;
    logic               pair_end_reg, pair_end_next;
    pfc_pkg::cell_t     cell_a_reg, cell_a_next;
    pfc_pkg::cell_t     out_idx1_reg, out_idx1_next;
    pfc_pkg::cell_t     out_idx2_reg, out_idx2_next;
    pfc_pkg::letter_t   out1_reg, out1_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    pfc_pkg::letter_t   m_letter_reg, m_letter_next;
    logic               m_last_reg, m_last_next;
    logic               m_end_reg, m_end_next;

    // memories
    pfc_pkg::letter_t   square_mem [pfc_pkg::NUM_CELLS];
    pfc_pkg::cell_t     cell_mem   [pfc_pkg::NUM_LETTERS];
    pfc_pkg::letter_t   square_rd_reg;
    pfc_pkg::cell_t     cell_rd_reg;
    pfc_pkg::cell_t     square_raddr;
    pfc_pkg::letter_t   cell_raddr;

    // shared placement path
    logic               place_req;
    logic               place_go;
    pfc_pkg::letter_t   place_letter;

    logic               in_xfer;
    logic               out_free;
    pfc_pkg::letter_t   in_raw;
    pfc_pkg::letter_t   in_fold;
    logic               raw_ok;

    // geometry in the compute step
    pfc_pkg::coord_t    r1, c1, r2, c2;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid & s_tready;
    assign in_raw   = s_tdata[4:0];
    assign raw_ok   = (in_raw <= pfc_pkg::LETTER_Z);
    assign in_fold  = pfc_pkg::fold_letter(in_raw);
    assign out_free = !m_valid_reg || m_tready;

    assign place_go = place_req && !used_reg[place_letter]
                      && (fill_count_reg < 5'(pfc_pkg::NUM_CELLS));

    assign square_raddr = (state_reg == ST_SQ1) ? out_idx1_reg : out_idx2_reg;
    assign cell_raddr   = (state_reg == ST_LKA) ? pair_a_reg : pair_b_reg;

    always_comb
    begin
        r1 = pfc_pkg::cell_row(cell_a_reg);
        c1 = pfc_pkg::cell_col(cell_a_reg, r1);
        r2 = pfc_pkg::cell_row(cell_rd_reg);
        c2 = pfc_pkg::cell_col(cell_rd_reg, r2);
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next        = state_reg;
        used_next         = used_reg;
        fill_count_next   = fill_count_reg;
        key_idx_next      = key_idx_reg;
        square_ready_next = square_ready_reg;
        held_letter_next  = held_letter_reg;
        held_valid_next   = held_valid_reg;
        pair_a_next       = pair_a_reg;
        pair_b_next       = pair_b_reg;
        pair_end_next     = pair_end_reg;
        cell_a_next       = cell_a_reg;
        out_idx1_next     = out_idx1_reg;
        out_idx2_next     = out_idx2_reg;
        out1_next         = out1_reg;
        m_valid_next      = m_valid_reg & ~m_tready;
        m_letter_next     = m_letter_reg;
        m_last_next       = m_last_reg;
        m_end_next        = m_end_reg;
        place_req         = 1'b0;
        place_letter      = in_fold;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (s_tuser)
                        pfc_pkg::CMD_KEY_LETTER:
                        begin
                            place_req = !square_ready_reg && raw_ok;
                        end
                        pfc_pkg::CMD_KEY_DONE:
                        begin
                            if (!square_ready_reg)
                            begin
                                key_idx_next = 5'd0;
                                state_next   = ST_FILL;
                            end
                        end
                        pfc_pkg::CMD_MSG_LETTER:
                        begin
                            if (square_ready_reg && raw_ok)
                            begin
                                if (!held_valid_reg)
                                begin
                                    held_letter_next = in_fold;
                                    held_valid_next  = 1'b1;
                                end
                                else
                                begin
                                    pair_a_next   = held_letter_reg;
                                    pair_end_next = 1'b0;
                                    state_next    = ST_LKA;
                                    if (!decrypt_mode_reg && in_fold == held_letter_reg)
                                    begin
                                        // doubled letter: insert filler, keep it held
                                        pair_b_next = pfc_pkg::fold_letter(filler_letter_reg);
                                    end
                                    else
                                    begin
                                        pair_b_next     = in_fold;
                                        held_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        pfc_pkg::CMD_MSG_END:
                        begin
                            if (held_valid_reg)
                            begin
                                held_valid_next = 1'b0;
                                if (square_ready_reg && !decrypt_mode_reg)
                                begin
                                    pair_a_next   = held_letter_reg;
                                    pair_b_next   = pfc_pkg::fold_letter(pad_letter_reg);
                                    pair_end_next = 1'b1;
                                    state_next    = ST_LKA;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL:
            begin
                place_req    = 1'b1;
                place_letter = key_idx_reg;
                key_idx_next = key_idx_reg + 5'd1;
                if (key_idx_reg == 5'(pfc_pkg::NUM_LETTERS - 1))
                begin
                    square_ready_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_LKA:
            begin
                state_next = ST_LKB;
            end
            ST_LKB:
            begin
                cell_a_next = cell_rd_reg;
                state_next  = ST_CALC;
            end
            ST_CALC:
            begin
                if (r1 == r2)
                begin
                    out_idx1_next = pfc_pkg::cell_index(r1,
                                        pfc_pkg::wrap_step(c1, decrypt_mode_reg));
                    out_idx2_next = pfc_pkg::cell_index(r2,
                                        pfc_pkg::wrap_step(c2, decrypt_mode_reg));
                end
                else if (c1 == c2)
                begin
                    out_idx1_next = pfc_pkg::cell_index(
                                        pfc_pkg::wrap_step(r1, decrypt_mode_reg), c1);
                    out_idx2_next = pfc_pkg::cell_index(
                                        pfc_pkg::wrap_step(r2, decrypt_mode_reg), c2);
                end
                else
                begin
                    // rectangle: swap columns
                    out_idx1_next = pfc_pkg::cell_index(r1, c2);
                    out_idx2_next = pfc_pkg::cell_index(r2, c1);
                end
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                out1_next  = square_rd_reg;
                state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                // square read data now holds the second letter; hold the address
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_letter_next = out1_reg;
                    m_last_next   = 1'b0;
                    m_end_next    = 1'b0;
                    state_next    = ST_OUT2;
                end
            end
            ST_OUT2:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_letter_next = square_rd_reg;
                    m_last_next   = 1'b1;
                    m_end_next    = pair_end_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (place_go)
        begin
            used_next[place_letter] = 1'b1;
            fill_count_next         = fill_count_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            used_reg         <= 26'd1 << pfc_pkg::LETTER_J;
            fill_count_reg   <= 5'd0;
            key_idx_reg      <= 5'd0;
            square_ready_reg <= 1'b0;
            held_letter_reg  <= 5'd0;
            held_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            fill_count_reg   <= fill_count_next;
            key_idx_reg      <= key_idx_next;
            square_ready_reg <= square_ready_next;
            held_letter_reg  <= held_letter_next;
            held_valid_reg   <= held_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_a_reg   <= pair_a_next;
        pair_b_reg   <= pair_b_next;
        pair_end_reg <= pair_end_next;
        cell_a_reg   <= cell_a_next;
        out_idx1_reg <= out_idx1_next;
        out_idx2_reg <= out_idx2_next;
        out1_reg     <= out1_next;
        m_letter_reg <= m_letter_next;
        m_last_reg   <= m_last_next;
        m_end_reg    <= m_end_next;
    end

    // ---------------- key square memories ----------------
    always_ff @(posedge clk)
    begin
        if (place_go)
        begin
            square_mem[fill_count_reg] <= place_letter;
            cell_mem[place_letter]     <= fill_count_reg;
        end
        square_rd_reg <= square_mem[square_raddr];
        cell_rd_reg   <= cell_mem[cell_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_letter_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_end_reg;

    // ---------------- assertions ----------------
    a_held_needs_square: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> square_ready_reg)
        else $error("held letter without a finished key square");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= 5'(pfc_pkg::NUM_CELLS))
        else $error("key square overfilled");

    a_used_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == 32'(fill_count_reg) + 32'd1)
        else $error("used-letter flags disagree with fill count");

    a_square_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(square_ready_reg) |-> fill_count_reg == 5'(pfc_pkg::NUM_CELLS))
        else $error("key square not full at key done");

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_end_reg) |-> m_last_reg)
        else $error("message end flag on first letter of a pair");

endmodule
